### rtl/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the source line tokenizer
// Result codes, token kinds, lexer modes and the result group that the lexer
// hands to the output queue.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int LINE_W          = 16;  // width of the line field on the port
  localparam int DEF_LINE_BITS   = 16;  // default line counter width (8..32)
  localparam int DEF_QUEUE_DEPTH = 4;   // result groups in the output queue
  localparam int MAX_RES         = 3;   // results one request can cause

  typedef enum logic [1:0] {
    RW_BYTE      = 2'd0,
    RW_TOKEN_END = 2'd1,
    RW_ERROR     = 2'd2
  } what_t;

  typedef enum logic [2:0] {
    TK_STRING     = 3'd0,
    TK_IDENTIFIER = 3'd1,
    TK_INTEGER    = 3'd2,
    TK_FLOAT      = 3'd3,
    TK_OPERATOR   = 3'd4
  } kind_t;

  typedef enum logic {
    EC_UNCLOSED_STRING = 1'b0,
    EC_BAD_NUMBER      = 1'b1
  } err_t;

  typedef enum logic [2:0] {
    LM_IDLE  = 3'd0,
    LM_STR   = 3'd1,
    LM_ESC   = 3'd2,
    LM_IDENT = 3'd3,
    LM_INT   = 3'd4,
    LM_DOT   = 3'd5,
    LM_FRAC  = 3'd6,
    LM_OPP   = 3'd7
  } lex_mode_t;

  typedef struct packed {
    what_t       what;
    logic [7:0]  byte_res;
    kind_t       kind;
    err_t        err;
  } entry_t;

  // All results of one request share the line number seen on arrival.
  typedef struct packed {
    entry_t [MAX_RES-1:0] res;
    logic [1:0]           n;
    logic [LINE_W-1:0]    line;
  } group_t;

endpackage

### rtl/slt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_if: channel interfaces of the source line tokenizer
// Character request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_line;

  modport source (output valid, ch, end_of_line, input ready);
  modport sink   (input valid, ch, end_of_line, output ready);
endinterface

interface slt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  what;
  logic [7:0]  byte_res;
  logic [2:0]  token_kind;
  logic        error_code;
  logic [15:0] line;
  logic        last;

  modport source (output valid, what, byte_res, token_kind, error_code, line, last,
                  input ready);
  modport sink   (input valid, what, byte_res, token_kind, error_code, line, last,
                  output ready);
endinterface

### rtl/slt_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_lexer: lexer state and single-pass step logic
// Holds mode, pending operator, line counter and halt flag; builds the
// result group of one accepted request.
// ----------------------------------------------------------------------------
module slt_lexer import slt_pkg::*; #(
  parameter int LINE_BITS = DEF_LINE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output group_t     grp,
  output logic       halted
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // # ( ) { } / ? + - * = ! ,
  function automatic logic is_op(logic [7:0] c);
    return c == 8'h23 || c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D ||
           c == CH_SLASH || c == 8'h3F || c == 8'h2B || c == 8'h2D || c == 8'h2A ||
           c == CH_EQ || c == CH_BANG || c == 8'h2C;
  endfunction

  function automatic entry_t mk(what_t w, logic [7:0] b, kind_t k, err_t e);
    entry_t r;
    r.what     = w;
    r.byte_res = b;
    r.kind     = k;
    r.err      = e;
    return r;
  endfunction

  lex_mode_t            mode, mode_next;
  logic [7:0]           pend, pend_next;
  logic [LINE_BITS-1:0] line_count, line_next;
  logic                 halted_next;
  logic                 again;
  logic [1:0]           n;

  always_comb begin
    grp         = '0;
    n           = 2'd0;
    mode_next   = mode;
    pend_next   = pend;
    line_next   = line_count;
    halted_next = halted;
    again       = 1'b0;

    if (!halted) begin
      case (mode)
        LM_STR: begin
          if (end_of_line) begin
            grp.res[n] = mk(RW_ERROR, 8'd0, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            halted_next = 1'b1; mode_next = LM_IDLE;
          end else if (ch == CH_BSLASH) begin
            mode_next = LM_ESC;
          end else begin
            grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            if (ch == CH_QUOTE) begin
              grp.res[n] = mk(RW_TOKEN_END, 8'd0, TK_STRING, EC_UNCLOSED_STRING);
              n = n + 2'd1;
              mode_next = LM_IDLE;
            end
          end
        end
        LM_ESC: begin
          if (!end_of_line && (ch == CH_BSLASH || ch == CH_QUOTE)) begin
            grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            mode_next = LM_STR;
          end else if (!end_of_line && ch == CH_N) begin
            grp.res[n] = mk(RW_BYTE, CH_LF, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            mode_next = LM_STR;
          end else if (!end_of_line && ch == CH_T) begin
            grp.res[n] = mk(RW_BYTE, CH_TAB, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            mode_next = LM_STR;
          end else begin
            // bad escape or line end inside an escape
            grp.res[n] = mk(RW_ERROR, 8'd0, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            halted_next = 1'b1; mode_next = LM_IDLE;
          end
        end
        LM_IDENT: begin
          if (!end_of_line && (is_alpha(ch) || is_digit(ch))) begin
            grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
          end else begin
            grp.res[n] = mk(RW_TOKEN_END, 8'd0, TK_IDENTIFIER, EC_UNCLOSED_STRING);
            n = n + 2'd1;
            mode_next = LM_IDLE; again = 1'b1;
          end
        end
        LM_INT, LM_FRAC: begin
          if (end_of_line || ch == CH_SPACE) begin
            grp.res[n] = mk(RW_TOKEN_END, 8'd0,
                            (mode == LM_INT) ? TK_INTEGER : TK_FLOAT, EC_UNCLOSED_STRING);
            n = n + 2'd1;
            mode_next = LM_IDLE; again = 1'b1;
          end else if (is_digit(ch)) begin
            grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
          end else if (ch == CH_DOT && mode == LM_INT) begin
            mode_next = LM_DOT;
          end else begin
            grp.res[n] = mk(RW_ERROR, 8'd0, TK_STRING, EC_BAD_NUMBER); n = n + 2'd1;
            halted_next = 1'b1; mode_next = LM_IDLE;
          end
        end
        LM_DOT: begin
          if (!end_of_line && is_digit(ch)) begin
            grp.res[n] = mk(RW_BYTE, CH_DOT, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            mode_next = LM_FRAC;
          end else begin
            grp.res[n] = mk(RW_ERROR, 8'd0, TK_STRING, EC_BAD_NUMBER); n = n + 2'd1;
            halted_next = 1'b1; mode_next = LM_IDLE;
          end
        end
        LM_OPP: begin
          if (!end_of_line &&
              ((ch == CH_EQ && (pend == CH_BANG || pend == CH_EQ)) ||
               (ch == CH_SLASH && pend == CH_SLASH))) begin
            grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
            grp.res[n] = mk(RW_TOKEN_END, 8'd0, TK_OPERATOR, EC_UNCLOSED_STRING);
            n = n + 2'd1;
            mode_next = LM_IDLE;
          end else begin
            grp.res[n] = mk(RW_TOKEN_END, 8'd0, TK_OPERATOR, EC_UNCLOSED_STRING);
            n = n + 2'd1;
            mode_next = LM_IDLE; again = 1'b1;
          end
        end
        default: begin
          mode_next = LM_IDLE;
          again     = 1'b1;
        end
      endcase

      // idle handling, also for the byte that closed a previous token
      if (again) begin
        if (end_of_line) begin
          if (line_count != LINE_MAX) begin
            line_next = line_count + 1'b1;
          end
        end else if (ch == CH_QUOTE) begin
          grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
          mode_next = LM_STR;
        end else if (is_alpha(ch)) begin
          grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
          mode_next = LM_IDENT;
        end else if (is_digit(ch)) begin
          grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
          mode_next = LM_INT;
        end else if (is_op(ch)) begin
          grp.res[n] = mk(RW_BYTE, ch, TK_STRING, EC_UNCLOSED_STRING); n = n + 2'd1;
          if (ch == CH_BANG || ch == CH_SLASH || ch == CH_EQ) begin
            pend_next = ch;
            mode_next = LM_OPP;
          end else begin
            grp.res[n] = mk(RW_TOKEN_END, 8'd0, TK_OPERATOR, EC_UNCLOSED_STRING);
            n = n + 2'd1;
          end
        end
      end
    end

    grp.n    = n;
    grp.line = LINE_W'(line_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= LM_IDLE;
      pend       <= 8'd0;
      line_count <= LINE_BITS'(1);
      halted     <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      pend       <= pend_next;
      line_count <= line_next;
      halted     <= halted_next;
    end
  end

endmodule

### rtl/slt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_queue: result group queue and unpacker
// Stores whole result groups and sends their results one per cycle while the
// result side is ready. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module slt_queue import slt_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  group_t       push_grp,
  output logic         space,
  slt_res_if.source    res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   level;
  logic [1:0]         sub;
  group_t             head;
  entry_t             cur;
  logic               take, pop, at_last;

  assign head    = mem[rd_ptr];
  assign cur     = head.res[sub];
  assign at_last = (sub == head.n - 2'd1);
  assign take    = res.valid && res.ready;
  assign pop     = take && at_last;
  assign space   = (level != CNT_W'(DEPTH));

  assign res.valid      = (level != '0);
  assign res.what       = cur.what;
  assign res.byte_res   = cur.byte_res;
  assign res.token_kind = cur.kind;
  assign res.error_code = cur.err;
  assign res.line       = head.line;
  assign res.last       = at_last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
      sub    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
        sub    <= 2'd0;
      end else if (take) begin
        sub <= sub + 2'd1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

### rtl/source_line_tokenizer.sv
`timescale 1ns / 1ps
// An accepted request's result group is registered in the queue together with the
//   lexer state update. Throughput: one character request per cycle; results
//   drain one per cycle while res_ch.ready is high, so requests that cause two or
//   three results stall the input once the queue fills.
// Reset (synchronous, rst high): lexer idle, line number 1, halt flag clear,
//   queue empty. No clearing pass; the block takes requests right after reset.
// ----------------------------------------------------------------------------
// source_line_tokenizer: streaming lexer for line-oriented source text
// Consumes one byte or end-of-line mark per request and emits content bytes,
// token ends (kind + line) and error results.
// ----------------------------------------------------------------------------
module source_line_tokenizer import slt_pkg::*; #(
  parameter int LINE_BITS   = DEF_LINE_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  slt_char_if.sink    char_ch,
  slt_res_if.source   res_ch
);

  // The lexer step is a single combinational pass from the request and the
  // current lexer state; its result group (up to three results) is written
  // into the queue at the same edge that updates the state. The queue
  // registers the results and hands them out one per cycle, so the input
  // keeps flowing while the result side is stalled, until the queue is full.

  group_t grp;
  logic   lex_halted;
  logic   space;
  logic   accept;

  // Ready depends only on queue room, never on the lexer mode.
  assign char_ch.ready = space;
  assign accept        = char_ch.valid && char_ch.ready;

  slt_lexer #(
    .LINE_BITS (LINE_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ch          (char_ch.ch),
    .end_of_line (char_ch.end_of_line),
    .grp         (grp),
    .halted      (lex_halted)
  );

  // Requests that cause no result (spaces and line ends while idle, escape
  // lead-ins, anything after an error) leave the queue alone.
  slt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && (grp.n != 2'd0)),
    .push_grp (grp),
    .space    (space),
    .res      (res_ch)
  );

  // Once halted, the lexer produces nothing more.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && lex_halted) |-> (grp.n == 2'd0))
    else $error("lexer produced results while halted");

  // An error is queued in the same edge that sets the halt flag.
  a_err_halted: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.what == RW_ERROR) |-> lex_halted)
    else $error("error result seen without halt flag");

  // An error is always the final result of its request.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.what == RW_ERROR) |-> res_ch.last)
    else $error("error result not marked last");

  // A request that reaches the halt state must have queued an error.
  a_halt_cause: assert property (@(posedge clk) disable iff (rst)
    (accept && !lex_halted) ##1 lex_halted |-> $past(grp.n != 2'd0))
    else $error("halt without an error result");

endmodule
